### hdl/mandelbrot_escape_pixel_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape pixel - assertion macros
// Shorthand for clocked implication checks, reset gated.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_MACROS_SVH

// Same-cycle implication.
`define MEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define MEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types, constants and helper functions of the Mandelbrot pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

  localparam int unsigned MAX_ITER_DEF = 200;

  // Q8.24 coordinates
  localparam int unsigned FRAC_W = 24;
  // |z|^2 >= 4 in Q16.48 means bit 50 or above is set
  localparam int unsigned ESC_BIT = 50;

  localparam logic signed [63:0] Q_HI = 64'sd2147483647;
  localparam logic signed [63:0] Q_LO = -64'sd2147483648;

  typedef enum logic [1:0] {
    REG_SHIFT_X     = 2'd0,
    REG_SHIFT_Y     = 2'd1,
    REG_INV_SCALE_X = 2'd2,
    REG_INV_SCALE_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Saturate to signed Q8.24.
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > Q_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // Largest v in 0..255 with den * v^k <= i * 255^k (k up to 10).
  // Elaboration-time only: builds the palette constants.
  function automatic logic [7:0] pal_level(input int unsigned i,
                                           input int unsigned den,
                                           input int unsigned k);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [7:0]   best;
    logic [7:0]   trial;
    rhs  = 128'(i);
    best = '0;
    for (int j = 0; j < 10; j++) begin
      if (j < int'(k)) rhs = rhs * 128'd255;
    end
    for (int b = 7; b >= 0; b--) begin
      trial = best | (8'd1 << b);
      lhs   = 128'(den);
      for (int j = 0; j < 10; j++) begin
        if (j < int'(k)) lhs = lhs * 128'(trial);
      end
      if (lhs <= rhs) best = trial;
    end
    return best;
  endfunction

endpackage

`default_nettype wire

### hdl/mep_mul.sv
// ----------------------------------------------------------------------------
// mep_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_mul (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [63:0]      prod_o
);

  logic signed [63:0] prod_q;
  logic signed [63:0] prod_d;

  assign prod_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### hdl/mep_palette.sv
// ----------------------------------------------------------------------------
// mep_palette
// Constant palette ROM: power curves 0.1 / 0.5 / 1 over the count range.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_palette #(
  parameter int unsigned MAX_ITER = mep_pkg::MAX_ITER_DEF
) (
  input  wire logic [$clog2(MAX_ITER+1)-1:0] cnt_i,
  output mep_pkg::rgb_t                      rgb_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITER + 1);
  localparam int unsigned IDX_W = $clog2(MAX_ITER);

  mep_pkg::rgb_t      rom [MAX_ITER];
  logic [IDX_W-1:0]   idx;

  for (genvar g = 0; g < int'(MAX_ITER); g++) begin : g_rom
    localparam logic [7:0] R = mep_pkg::pal_level(g, MAX_ITER - 1, 10);
    localparam logic [7:0] G = mep_pkg::pal_level(g, MAX_ITER - 1, 2);
    localparam logic [7:0] B = mep_pkg::pal_level(g, MAX_ITER - 1, 1);
    assign rom[g] = '{red: R, green: G, blue: B};
  end

  // a count at the limit shares the last entry
  always_comb begin
    if (cnt_i > CNT_W'(MAX_ITER - 1)) begin
      idx = IDX_W'(MAX_ITER - 1);
    end else begin
      idx = cnt_i[IDX_W-1:0];
    end
  end

  assign rgb_o = rom[idx];

endmodule

`default_nettype wire

### hdl/mandelbrot_escape_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time evaluator for one pixel, with a palette color per count.
// ----------------------------------------------------------------------------
// One pixel (col, row) is in flight at a time. The pixel is mapped to
// c = (pix + shift) * inv_scale in signed Q8.24 (saturating), then
// z = z^2 + c is iterated from z = c while |z|^2 < 4 and the count is below
// MAX_ITER. Every multiply - both coordinate mappings and the x*x, y*y, x*y
// of each iteration - goes through a single registered 32x32 multiplier, so
// one iteration runs through ST_SQX, ST_SQY, ST_XY and ST_UPD in turn. A pixel
// occupies the block through ST_MAPX, ST_MAPY and ST_LDY (mapping), one pass
// of the iteration states per evaluated iteration including the one that
// escapes, and ST_FIN (load the result), which also waits while the previous
// result is still held in the output register. in_stall_o is high for that
// whole time. The result sits in an output register, so the next pixel is
// taken while it waits.
// Configuration writes are only legal while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_pixel #(
  parameter int unsigned MAX_ITER = mep_pkg::MAX_ITER_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i,
  // pixel in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] col_i,
  input  wire logic [11:0] row_i,
  // result out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       iterations_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITER + 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MAPX = 9'b000000010,  // multiply x mapping
    ST_MAPY = 9'b000000100,  // load cx, multiply y mapping
    ST_LDY  = 9'b000001000,  // load cy
    ST_SQX  = 9'b000010000,  // x*x
    ST_SQY  = 9'b000100000,  // y*y, latch x^2
    ST_XY   = 9'b001000000,  // x*y, escape test and x^2 - y^2
    ST_UPD  = 9'b010000000,  // new z, count
    ST_FIN  = 9'b100000000   // hand result to the output register
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [23:0] shift_x_q, shift_y_q;
  logic [30:0] scale_x_q, scale_y_q;

  // working registers
  logic [11:0]        col_q, row_q;
  logic signed [31:0] cx_q, cy_q, x_q, y_q;
  logic signed [31:0] cx_d, cy_d, x_d, y_d;
  logic signed [63:0] xs_q, xs_d;
  logic signed [63:0] diff_q, diff_d;
  logic               esc_q, esc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  iter_q, iter_d;
  mep_pkg::rgb_t rgb_q, rgb_d;

  // shared unit
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic signed [24:0] px, py;
  logic [64:0]        mag_sum;
  logic signed [40:0] nx_sum;
  logic signed [41:0] ny_sum;
  mep_pkg::rgb_t      pal_rgb;
  logic               in_xfer;
  logic               out_free;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // pixel plus offset, 25-bit signed
  assign px = $signed({13'd0, col_q}) + $signed({shift_x_q[23], shift_x_q});
  assign py = $signed({13'd0, row_q}) + $signed({shift_y_q[23], shift_y_q});

  always_comb begin
    unique case (state_q)
      ST_MAPX: begin
        mul_a = 32'(px);
        mul_b = $signed({1'b0, scale_x_q});
      end
      ST_MAPY: begin
        mul_a = 32'(py);
        mul_b = $signed({1'b0, scale_y_q});
      end
      ST_SQX: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_SQY: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = y_q;
      end
    endcase
  end

  mep_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  mep_palette #(
    .MAX_ITER (MAX_ITER)
  ) u_palette (
    .cnt_i (cnt_q),
    .rgb_o (pal_rgb)
  );

  // in ST_XY the product register holds y^2; in ST_UPD it holds x*y
  assign mag_sum = {1'b0, xs_q} + {1'b0, prod};
  assign nx_sum  = 41'(diff_q >>> mep_pkg::FRAC_W) + 41'(cx_q);
  assign ny_sum  = 42'(prod >>> (mep_pkg::FRAC_W - 1)) + 42'(cy_q);

  always_comb begin
    state_d     = state_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    x_d         = x_q;
    y_d         = y_q;
    xs_d        = xs_q;
    diff_d      = diff_q;
    esc_d       = esc_q;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    rgb_d       = rgb_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MAPX;
      end
      ST_MAPX: begin
        state_d = ST_MAPY;
      end
      ST_MAPY: begin
        cx_d    = mep_pkg::sat_q(prod);
        x_d     = mep_pkg::sat_q(prod);
        state_d = ST_LDY;
      end
      ST_LDY: begin
        cy_d    = mep_pkg::sat_q(prod);
        y_d     = mep_pkg::sat_q(prod);
        cnt_d   = '0;
        state_d = ST_SQX;
      end
      ST_SQX: begin
        state_d = ST_SQY;
      end
      ST_SQY: begin
        xs_d    = prod;
        state_d = ST_XY;
      end
      ST_XY: begin
        esc_d   = |mag_sum[64:mep_pkg::ESC_BIT];
        diff_d  = xs_q - prod;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (esc_q) begin
          state_d = ST_FIN;
        end else begin
          x_d   = mep_pkg::sat_q(64'(nx_sum));
          y_d   = mep_pkg::sat_q(64'(ny_sum));
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(MAX_ITER - 1)) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_SQX;
          end
        end
      end
      ST_FIN: begin
        // wait until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          iter_d      = 8'(cnt_q);
          rgb_d       = pal_rgb;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      scale_x_q   <= 31'd65536;
      scale_y_q   <= 31'd65536;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (mep_pkg::reg_idx_e'(cfg_idx_i))
          mep_pkg::REG_SHIFT_X:     shift_x_q <= cfg_data_i[23:0];
          mep_pkg::REG_SHIFT_Y:     shift_y_q <= cfg_data_i[23:0];
          mep_pkg::REG_INV_SCALE_X: scale_x_q <= cfg_data_i;
          mep_pkg::REG_INV_SCALE_Y: scale_y_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    x_q    <= x_d;
    y_q    <= y_d;
    xs_q   <= xs_d;
    diff_q <= diff_d;
    esc_q  <= esc_d;
    cnt_q  <= cnt_d;
    iter_q <= iter_d;
    rgb_q  <= rgb_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign iterations_o = iter_q;
  assign red_o        = rgb_q.red;
  assign green_o      = rgb_q.green;
  assign blue_o       = rgb_q.blue;

endmodule

`default_nettype wire

### hdl/mep_checker.sv
// ----------------------------------------------------------------------------
// mep_checker
// Port-level checks on the Mandelbrot pixel block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_pixel_macros.svh"

module mep_checker #(
  parameter int unsigned MAX_ITER = mep_pkg::MAX_ITER_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  iterations_o,
  input wire logic [7:0]  red_o,
  input wire logic [7:0]  green_o,
  input wire logic [7:0]  blue_o
);

  localparam bit SMALL_MAX = (MAX_ITER <= 255);

  logic in_xfer;
  logic out_hold;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_hold  = out_valid_o && out_stall_i;

  // stalled result stays put
  `MEP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_hold,
    out_valid_o && $stable(iterations_o) && $stable(red_o) && $stable(green_o) && $stable(blue_o))

  // one pixel at a time: busy right after a transfer
  `MEP_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_xfer, in_stall_o)

  // immediate escape maps to black
  `MEP_ASSERT_IMP(a_zero_black, clk_i, rst_ni,
    SMALL_MAX && out_valid_o && (iterations_o == 8'd0),
    (red_o == 8'd0) && (green_o == 8'd0) && (blue_o == 8'd0))

  // not escaped maps to full intensity
  `MEP_ASSERT_IMP(a_limit_full, clk_i, rst_ni,
    SMALL_MAX && out_valid_o && (iterations_o == 8'(MAX_ITER)),
    (red_o == 8'd255) && (green_o == 8'd255) && (blue_o == 8'd255))

endmodule

bind mandelbrot_escape_pixel mep_checker #(.MAX_ITER(MAX_ITER)) u_mep_checker (.*);

`default_nettype wire
